// ===== rtl/adl_pkg.sv =====
// Shared types, constants and helpers for the Adler-32 checksum block.
package adl_pkg;

  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned BSUM_W    = 11;  // up to 8 * 255
  localparam int unsigned WSUM_W    = 14;  // up to 36 * 255
  localparam int unsigned LANE_W    = 12;  // weight times byte

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // One word after the lane stage: sums found by the lanes plus control.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [BSUM_W-1:0] byte_sum;
    logic [WSUM_W-1:0] wsum;
    logic              first;
    logic              last;
    logic [31:0]       seed;
  } stage_t;

  // Final reduction for a value known to stay below twice the modulus.
  function automatic logic [15:0] mod_fix(input logic [16:0] x);
    logic [16:0] d;
    d = x - ADLER_MOD;
    return (x >= ADLER_MOD) ? d[15:0] : x[15:0];
  endfunction

endpackage

// ===== rtl/adl_if.sv =====
// Valid/ready channel interfaces for message words and checksum results.
interface adl_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;
  logic [3:0]  byte_count;
  logic        first_item;
  logic        last_item;
  logic [31:0] seed;

  modport source (output valid, data_bytes, byte_count, first_item, last_item, seed,
                  input ready);
  modport sink   (input valid, data_bytes, byte_count, first_item, last_item, seed,
                  output ready);
endinterface

interface adl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, checksum, input ready);
  modport sink   (input valid, checksum, output ready);
endinterface

// ===== rtl/adler32_checksum.sv =====
// Top level of the Adler-32 checksum block.
// Takes one word of up to BYTES_PER_ITEM message bytes (byte 0 in bits 7:0,
// first in order) per clock and returns the checksum {weighted sum, byte sum}
// when a word marked last_item has been folded in. A word marked first_item
// loads the sums from seed before its bytes. Throughput is one word per
// cycle unless held; a last word passes the lane-stage register, then its
// checksum waits in the output register. The pipeline holds only while a
// checksum waits in the output register and out_ch.ready is low.
module adler32_checksum #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  adl_in_if.sink           in_ch,
  adl_out_if.source        out_ch
);
  import adl_pkg::*;

  logic   adv;
  stage_t st;
  logic   st_valid;
  logic   out_valid;

  // Advance everything unless a result is stuck at the output.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  adl_front #(.BYTES_PER_ITEM(BYTES_PER_ITEM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_ch.valid),
    .data_bytes (in_ch.data_bytes),
    .byte_count (in_ch.byte_count),
    .first_item (in_ch.first_item),
    .last_item  (in_ch.last_item),
    .seed       (in_ch.seed),
    .st         (st),
    .st_valid   (st_valid)
  );

  adl_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .st        (st),
    .st_valid  (st_valid),
    .out_valid (out_valid),
    .checksum  (out_ch.checksum)
  );

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/adl_lane.sv =====
// One byte lane: masks its byte and forms its position-weighted term.
module adl_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic [7:0]                    lane_byte,
  input  logic [adl_pkg::CNT_W-1:0]     count,
  output logic [7:0]                    byte_o,
  output logic [adl_pkg::LANE_W-1:0]    weighted_o
);
  import adl_pkg::*;

  logic             active;
  logic [CNT_W-1:0] weight;

  assign active     = (CNT_W'(LANE) < count);
  assign weight     = count - CNT_W'(LANE);
  assign byte_o     = active ? lane_byte : 8'd0;
  assign weighted_o = active ? (LANE_W'(weight) * LANE_W'(lane_byte)) : '0;

endmodule

// ===== rtl/adl_front.sv =====
// Lane stage: saturates the count, runs the byte lanes and merges their sums.
module adl_front #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [63:0]             data_bytes,
  input  logic [3:0]              byte_count,
  input  logic                    first_item,
  input  logic                    last_item,
  input  logic [31:0]             seed,
  output adl_pkg::stage_t         st,
  output logic                    st_valid
);
  import adl_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(BYTES_PER_ITEM);

  logic [CNT_W-1:0]  count_sat;
  logic [7:0]        lane_byte [BYTES_PER_ITEM];
  logic [LANE_W-1:0] lane_wt   [BYTES_PER_ITEM];
  logic [BSUM_W-1:0] bsum;
  logic [WSUM_W-1:0] wsum;
  stage_t            st_r, st_nxt;
  logic              st_valid_r;

  assign count_sat = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;

  for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
    adl_lane #(.LANE(k)) u_lane (
      .lane_byte  (data_bytes[8*k +: 8]),
      .count      (count_sat),
      .byte_o     (lane_byte[k]),
      .weighted_o (lane_wt[k])
    );
  end

  // Merge the lanes.
  always_comb begin
    bsum = '0;
    wsum = '0;
    for (int k = 0; k < BYTES_PER_ITEM; k++) begin
      bsum = bsum + BSUM_W'(lane_byte[k]);
      wsum = wsum + WSUM_W'(lane_wt[k]);
    end
    st_nxt.count    = count_sat;
    st_nxt.byte_sum = bsum;
    st_nxt.wsum     = wsum;
    st_nxt.first    = first_item;
    st_nxt.last     = last_item;
    st_nxt.seed     = seed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (adv) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st       = st_r;
  assign st_valid = st_valid_r;

endmodule

// ===== rtl/adl_accum.sv =====
// Running sums: folds each word into the two mod-65521 sums, holds the result.
module adl_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  adl_pkg::stage_t st,
  input  logic            st_valid,
  output logic            out_valid,
  output logic [31:0]     checksum
);
  import adl_pkg::*;

  logic [15:0] a_r, a_nxt;
  logic [15:0] b_r, b_nxt;
  logic        out_valid_r;
  logic [31:0] checksum_r;

  logic [15:0] base_a, base_b;
  logic [16:0] a_sum;
  logic [19:0] ca;
  logic [20:0] b_sum;
  logic [16:0] b_fold;

  always_comb begin
    base_a = st.first ? st.seed[15:0]  : a_r;
    base_b = st.first ? st.seed[31:16] : b_r;
    ca     = 20'(st.count) * 20'(base_a);
    a_sum  = 17'(base_a) + 17'(st.byte_sum);
    b_sum  = 21'(base_b) + 21'(ca) + 21'(st.wsum);
    // 2^16 is 15 mod 65521: fold the high bits back in.
    b_fold = 17'(b_sum[15:0]) + 17'(b_sum[20:16]) * 17'd15;
    if (st.count != '0) begin
      a_nxt = mod_fix(a_sum);
      b_nxt = mod_fix(b_fold);
    end else begin
      // no bytes: keep the sums unreduced
      a_nxt = base_a;
      b_nxt = base_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid && st.last;
      if (st_valid) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_valid && st.last) begin
      checksum_r <= {b_nxt, a_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign checksum  = checksum_r;

endmodule

// ===== sim/tb_adler32_checksum.sv =====
// Testbench for adler32_checksum: directed and random messages against running sums.
module tb_adler32_checksum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LANES       = 8;
  localparam int unsigned ADLER_PRIME = 65521;
  localparam int unsigned RAND_WORDS  = 1250;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        first;
    logic        last;
    logic [31:0] seed;
  } word_t;

  logic clk;
  logic rst_n;

  adl_in_if  in_ch ();
  adl_out_if out_ch ();

  adler32_checksum #(.BYTES_PER_ITEM(LANES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t           word_q[$];
  logic [31:0]     checksum_q[$];
  int unsigned     sum_a;
  int unsigned     sum_b;
  int unsigned     error_cnt;
  int unsigned     words_in;
  int unsigned     cycle_cnt;
  int unsigned     send_gap;
  int unsigned     recv_stall;
  int unsigned     hold_left;
  bit              hold_done;
  bit              stim_go;
  logic            in_took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, sometimes short pauses, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_cnt++;
  endtask

  // Fold one accepted word into the running sums; queue the checksum on a last word.
  function automatic void fold_word(input word_t w);
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int unsigned byt;
    n = (w.count > LANES) ? LANES : w.count;
    if (w.first) begin
      sum_a = w.seed[15:0];
      sum_b = w.seed[31:16];
    end
    // an empty word leaves the sums unreduced
    if (n != 0) begin
      a = sum_a;
      b = sum_b + n * a;
      for (int unsigned k = 0; k < n; k++) begin
        byt = w.data[8*k +: 8];
        b += (n - k) * byt;
        a += byt;
      end
      sum_a = a % ADLER_PRIME;
      sum_b = b % ADLER_PRIME;
    end
    if (w.last) checksum_q.push_back({sum_b[15:0], sum_a[15:0]});
  endfunction

  task automatic queue_word(input logic [63:0] data, input logic [3:0] count,
                            input logic first, input logic last, input logic [31:0] seed);
    word_t w;
    w.data  = data;
    w.count = count;
    w.first = first;
    w.last  = last;
    w.seed  = seed;
    word_q.push_back(w);
  endtask

  function automatic logic [63:0] rand_data();
    if ($urandom_range(9) == 0) return '1;
    if ($urandom_range(19) == 0) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] rand_count();
    if ($urandom_range(99) < 70) return 4'(LANES);
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [31:0] rand_seed();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 32'd1;
    if (r < 8) return $urandom;
    return {16'($urandom_range(65521, 65535)), 16'($urandom_range(65521, 65535))};
  endfunction

  // Driver: present words at the falling edge, hold each until taken.
  always @(negedge clk) begin
    if (stim_go) begin
      if (in_ch.valid && !in_took) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (word_q.size() > 0) begin
        word_t w;
        w = word_q.pop_front();
        in_ch.data_bytes <= w.data;
        in_ch.byte_count <= w.count;
        in_ch.first_item <= w.first;
        in_ch.last_item  <= w.last;
        in_ch.seed       <= w.seed;
        in_ch.valid      <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (stim_go) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(99) < 25) recv_stall = pick_gap();
      end
    end
  end

  // Monitor: track accepted words, check returned checksums, watch the clock budget.
  always @(posedge clk) begin
    word_t w;
    logic [31:0] want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        w.data  = in_ch.data_bytes;
        w.count = in_ch.byte_count;
        w.first = in_ch.first_item;
        w.last  = in_ch.last_item;
        w.seed  = in_ch.seed;
        fold_word(w);
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (checksum_q.size() == 0) begin
          report_mismatch($sformatf("unexpected checksum %08h", out_ch.checksum));
        end else begin
          want = checksum_q.pop_front();
          if (out_ch.checksum !== want)
            report_mismatch($sformatf("checksum %08h, want %08h", out_ch.checksum, want));
        end
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned queued;
    sum_a        = 0;
    sum_b        = 0;
    error_cnt    = 0;
    words_in     = 0;
    cycle_cnt    = 0;
    send_gap     = 0;
    recv_stall   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    stim_go      = 1'b0;
    in_took      = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_bytes = '0;
    in_ch.byte_count = '0;
    in_ch.first_item = 1'b0;
    in_ch.last_item  = 1'b0;
    in_ch.seed       = '0;
    out_ch.ready     = 1'b0;

    // continue from the reset sums without a first word
    queue_word(64'h0000_0000_0003_0201, 4'd3, 1'b0, 1'b1, 32'hdead_beef);
    // empty messages return the seed untouched, even above the modulus
    queue_word('1, 4'd0, 1'b1, 1'b1, 32'hffff_ffff);
    queue_word('0, 4'd0, 1'b1, 1'b1, 32'hfff1_fff0);
    // unreduced seed survives empty words, then gets reduced by the first byte
    queue_word('1, 4'd0, 1'b1, 1'b0, 32'hfff5_fffe);
    queue_word('1, 4'd0, 1'b0, 1'b0, 32'h0);
    queue_word('0, 4'd1, 1'b0, 1'b1, 32'h0);
    // all-ones bytes at full width
    queue_word('1, 4'd8, 1'b1, 1'b1, 32'hfff0_fff0);
    // counts above the lane count saturate
    queue_word('1, 4'd15, 1'b1, 1'b1, 32'h1);
    queue_word(64'h8877_6655_4433_2211, 4'd9, 1'b1, 1'b1, 32'h1);
    // bytes past the count are ignored
    queue_word('0, 4'd8, 1'b1, 1'b0, 32'h0);
    queue_word('1, 4'd4, 1'b0, 1'b1, 32'h0);
    // continue from the last checksum without a first word
    queue_word(64'h0000_0000_0000_a55a, 4'd2, 1'b0, 1'b1, 32'h0);
    queue_word(64'h1234_5678_9abc_def0, 4'd5, 1'b0, 1'b0, 32'hffff_ffff);
    queue_word('1, 4'd0, 1'b0, 1'b1, 32'h0);
    // known text: "Wikipedia" gives 11e60398
    queue_word(64'h6964_6570_696b_6957, 4'd8, 1'b1, 1'b0, 32'h1);
    queue_word(64'h0000_0000_0000_0061, 4'd1, 1'b0, 1'b1, 32'h0);
    // a new first word restarts an open message
    queue_word(64'h0000_0000_0000_ffff, 4'd2, 1'b1, 1'b0, 32'h0000_0001);
    queue_word(64'h0102_0304_0506_0708, 4'd7, 1'b1, 1'b1, 32'h8000_0000);
    queue_word(64'h0000_0000_0000_00ff, 4'd1, 1'b1, 1'b1, 32'h0);
    queue_word(64'hffff_ffff_ffff_ffff, 4'd6, 1'b1, 1'b1, 32'hffee_ffdd);

    queued = 0;
    while (queued < RAND_WORDS) begin
      if ($urandom_range(9) == 0) begin
        // noise: arbitrary flags
        queue_word(rand_data(), 4'($urandom_range(15)), 1'($urandom), 1'($urandom), $urandom);
        queued++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++)
          queue_word(rand_data(), rand_count(), i == 0, i == len - 1,
                     (i == 0) ? rand_seed() : $urandom);
        queued += len;
      end
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    stim_go = 1'b1;

    do @(posedge clk);
    while (word_q.size() != 0 || in_ch.valid || checksum_q.size() != 0);
    repeat (10) @(posedge clk);

    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== adler32_checksum.f =====
rtl/adl_pkg.sv
rtl/adl_if.sv
rtl/adl_lane.sv
rtl/adl_front.sv
rtl/adl_accum.sv
rtl/adler32_checksum.sv
sim/tb_adler32_checksum.sv
